### src/ir_onoff_frame_transceiver_macros.svh
// Assertion macros used by the checker file of the IR on-off frame transceiver.
`ifndef IR_ONOFF_FRAME_TRANSCEIVER_MACROS_SVH
`define IR_ONOFF_FRAME_TRANSCEIVER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent, outside reset.
`define IOFT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent, outside reset.
`define IOFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ioft_pkg.sv
// Types and constants shared by the IR on-off frame transceiver modules.
package ioft_pkg;

    localparam int WORD_BITS    = 15;
    localparam int SENSOR_COUNT = 8;
    localparam int SAMPLE_BITS  = 12;
    localparam int POS_W        = $clog2(WORD_BITS);
    localparam int DELAY_W      = 4;
    localparam int PEND_W       = 7;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_IDX_W    = 1;

    localparam logic CMD_FRAME   = 1'b0;
    localparam logic CMD_ENQUEUE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_DELAY = 1'b1;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic                 cmd;
        sample_t              sensor_0;
        sample_t              sensor_1;
        sample_t              sensor_2;
        sample_t              sensor_3;
        sample_t              sensor_4;
        sample_t              sensor_5;
        sample_t              sensor_6;
        sample_t              sensor_7;
        logic [WORD_BITS-1:0] tx_word;
    } in_item_t;

    typedef struct packed {
        logic                    ir_on;
        logic [SENSOR_COUNT-1:0] near_mask;
        logic                    rx_word_valid;
        logic [WORD_BITS-1:0]    rx_word;
        logic                    rx_frame_end;
        logic                    tx_full;
        logic [PEND_W-1:0]       tx_pending;
    } out_item_t;

    // What one sensor lane reports to the merging stage.
    typedef struct packed {
        logic near;   // reading strictly below the threshold
        logic hit;    // reading at or below the threshold
    } lane_res_t;

endpackage

### src/ir_onoff_frame_transceiver.sv
// Top level of the IR on-off frame transceiver: transmit queue, bit timing and receive framing.
// A result item is registered in the output register, or in the skid stage while the output is stalled.
// Throughput: one item per cycle while the skid stage is empty; all link state is updated in the single accept cycle.
// The transmit queue memory is read in advance at the next head address.
// Reset (aresetn low, synchronous) clears all control state; the queue memory is not cleared.
// Configuration resets to threshold zero and signal delay one.
module ir_onoff_frame_transceiver
    import ioft_pkg::*;
#(
    parameter int TX_DEPTH   = 64,
    parameter int FRAME_BITS = 75
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input channel.
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    // Result channel.
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    localparam int PTR_W = $clog2(TX_DEPTH);
    localparam int CNT_W = $clog2(TX_DEPTH + 1);
    localparam int RXC_W = $clog2(FRAME_BITS);

    // Configuration registers.
    sample_t              threshold_reg;
    logic [DELAY_W-1:0]   signal_delay_reg;

    // Link state.
    logic [DELAY_W-1:0]   delay_count_reg, delay_count_next;
    logic [PTR_W-1:0]     tx_head_reg, tx_head_next;
    logic [PTR_W-1:0]     tx_tail_reg, tx_tail_next;
    logic [CNT_W-1:0]     tx_count_reg, tx_count_next;
    logic [POS_W-1:0]     tx_bit_idx_reg, tx_bit_idx_next;
    logic                 ir_state_reg, ir_state_next;
    logic                 rx_active_reg, rx_active_next;
    logic [RXC_W-1:0]     rx_bit_count_reg, rx_bit_count_next;
    logic [POS_W-1:0]     rx_pos_reg, rx_pos_next;
    logic [WORD_BITS-1:0] rx_shift_reg, rx_shift_next;

    // Queue memory and its head bypass.
    logic                 q_we;
    logic [WORD_BITS-1:0] q_rdata;
    logic                 byp_hit_reg;
    logic [WORD_BITS-1:0] byp_data_reg;
    logic [WORD_BITS-1:0] head_word;

    // Output register and skid stage.
    logic                 out_valid_reg;
    out_item_t            out_data_reg;
    logic                 skid_valid_reg;
    out_item_t            skid_data_reg;

    // Sensor lanes.
    sample_t   [SENSOR_COUNT-1:0] sensors;
    lane_res_t [SENSOR_COUNT-1:0] lane_res;
    logic      [SENSOR_COUNT-1:0] near_mask;
    logic                         rx_bit;

    // Receive working values.
    logic [WORD_BITS-1:0] rx_shift_base;
    logic [POS_W-1:0]     rx_pos_base;
    logic [RXC_W-1:0]     rx_cnt_base;
    logic [WORD_BITS-1:0] rx_word_new;

    logic      accept;
    out_item_t result;

    // The skid stage absorbs one item while the output register is stalled, so the
    // input side never waits on the output handshake combinationally.
    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= '0;
            signal_delay_reg <= DELAY_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_THRESHOLD: begin
                    threshold_reg <= cfg_wdata[SAMPLE_BITS-1:0];
                end
                REG_SIGNAL_DELAY: begin
                    signal_delay_reg <= cfg_wdata[DELAY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // One compare lane per sensor, then the merging stage.
    assign sensors[0] = s_data.sensor_0;
    assign sensors[1] = s_data.sensor_1;
    assign sensors[2] = s_data.sensor_2;
    assign sensors[3] = s_data.sensor_3;
    assign sensors[4] = s_data.sensor_4;
    assign sensors[5] = s_data.sensor_5;
    assign sensors[6] = s_data.sensor_6;
    assign sensors[7] = s_data.sensor_7;

    for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
        ioft_lane u_lane (
            .sample    (sensors[g]),
            .threshold (threshold_reg),
            .result    (lane_res[g])
        );
    end

    ioft_merge u_merge (
        .lane_res  (lane_res),
        .near_mask (near_mask),
        .rx_bit    (rx_bit)
    );

    // The memory is read every cycle at the next head address, so the head word is
    // ready in the following cycle. A write into that same address lands in the
    // bypass register instead, since the read returns the old contents then.
    ioft_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (TX_DEPTH)
    ) u_queue (
        .clk   (aclk),
        .we    (q_we),
        .waddr (tx_tail_reg),
        .wdata (s_data.tx_word),
        .raddr (tx_head_next),
        .rdata (q_rdata)
    );

    assign head_word = byp_hit_reg ? byp_data_reg : q_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_hit_reg <= 1'b0;
        end else begin
            byp_hit_reg <= q_we && (tx_tail_reg == tx_head_next);
        end
        byp_data_reg <= s_data.tx_word;
    end

    // Next-state logic for one accepted item.
    always_comb begin
        delay_count_next  = delay_count_reg;
        tx_head_next      = tx_head_reg;
        tx_tail_next      = tx_tail_reg;
        tx_count_next     = tx_count_reg;
        tx_bit_idx_next   = tx_bit_idx_reg;
        ir_state_next     = ir_state_reg;
        rx_active_next    = rx_active_reg;
        rx_bit_count_next = rx_bit_count_reg;
        rx_pos_next       = rx_pos_reg;
        rx_shift_next     = rx_shift_reg;
        q_we              = 1'b0;
        result            = '0;

        // A new frame starts from a clean word and bit count.
        rx_shift_base = rx_active_reg ? rx_shift_reg : '0;
        rx_pos_base   = rx_active_reg ? rx_pos_reg : '0;
        rx_cnt_base   = rx_active_reg ? rx_bit_count_reg : '0;
        rx_word_new   = rx_shift_base | (rx_bit ? (WORD_BITS'(1) << rx_pos_base) : '0);

        if (accept) begin
            if (s_data.cmd == CMD_ENQUEUE) begin
                // A full queue drops the codeword and flags it.
                if (tx_count_reg == CNT_W'(TX_DEPTH)) begin
                    result.tx_full = 1'b1;
                end else begin
                    q_we          = 1'b1;
                    tx_tail_next  = (tx_tail_reg == PTR_W'(TX_DEPTH - 1)) ?
                                    '0 : tx_tail_reg + PTR_W'(1);
                    tx_count_next = tx_count_reg + CNT_W'(1);
                end
            end else begin
                result.near_mask = near_mask;
                // The delay counter wraps freely, so lowering the delay below the
                // current count simply postpones the next bit period.
                if (delay_count_reg != signal_delay_reg) begin
                    delay_count_next = delay_count_reg + DELAY_W'(1);
                end else begin
                    delay_count_next = '0;

                    // Transmit: next bit of the head codeword, LSB first.
                    if (tx_count_reg != '0) begin
                        ir_state_next = head_word[tx_bit_idx_reg];
                        if (tx_bit_idx_reg == POS_W'(WORD_BITS - 1)) begin
                            tx_bit_idx_next = '0;
                            tx_head_next    = (tx_head_reg == PTR_W'(TX_DEPTH - 1)) ?
                                              '0 : tx_head_reg + PTR_W'(1);
                            tx_count_next   = tx_count_reg - CNT_W'(1);
                        end else begin
                            tx_bit_idx_next = tx_bit_idx_reg + POS_W'(1);
                        end
                    end else begin
                        ir_state_next = 1'b0;
                    end

                    // Receive: the first one bit opens a frame.
                    if (rx_active_reg || rx_bit) begin
                        rx_active_next = 1'b1;
                        if ((RXC_W + 1)'(rx_cnt_base) + (RXC_W + 1)'(1) ==
                            (RXC_W + 1)'(FRAME_BITS)) begin
                            // Last bit of the frame, a partial word included.
                            result.rx_word_valid = 1'b1;
                            result.rx_frame_end  = 1'b1;
                            result.rx_word       = rx_word_new;
                            rx_shift_next        = '0;
                            rx_bit_count_next    = '0;
                            rx_pos_next          = '0;
                            rx_active_next       = 1'b0;
                        end else begin
                            rx_bit_count_next = rx_cnt_base + RXC_W'(1);
                            if (rx_pos_base == POS_W'(WORD_BITS - 1)) begin
                                result.rx_word_valid = 1'b1;
                                result.rx_word       = rx_word_new;
                                rx_shift_next        = '0;
                                rx_pos_next          = '0;
                            end else begin
                                rx_shift_next = rx_word_new;
                                rx_pos_next   = rx_pos_base + POS_W'(1);
                            end
                        end
                    end
                end
            end
        end

        result.ir_on      = ir_state_next;
        result.tx_pending = PEND_W'(tx_count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_count_reg  <= '0;
            tx_head_reg      <= '0;
            tx_tail_reg      <= '0;
            tx_count_reg     <= '0;
            tx_bit_idx_reg   <= '0;
            ir_state_reg     <= 1'b0;
            rx_active_reg    <= 1'b0;
            rx_bit_count_reg <= '0;
            rx_pos_reg       <= '0;
            rx_shift_reg     <= '0;
        end else begin
            delay_count_reg  <= delay_count_next;
            tx_head_reg      <= tx_head_next;
            tx_tail_reg      <= tx_tail_next;
            tx_count_reg     <= tx_count_next;
            tx_bit_idx_reg   <= tx_bit_idx_next;
            ir_state_reg     <= ir_state_next;
            rx_active_reg    <= rx_active_next;
            rx_bit_count_reg <= rx_bit_count_next;
            rx_pos_reg       <= rx_pos_next;
            rx_shift_reg     <= rx_shift_next;
        end
    end

    // Output register with a one-item skid stage behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_ready) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    out_data_reg   <= skid_data_reg;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= accept;
                    if (accept) begin
                        out_data_reg <= result;
                    end
                end
            end else if (accept) begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= result;
            end
        end
    end

endmodule

### src/ioft_lane.sv
// One sensor lane: compares a single reading against the threshold.
module ioft_lane
    import ioft_pkg::*;
(
    input  sample_t   sample,
    input  sample_t   threshold,
    output lane_res_t result
);

    always_comb begin
        result.near = (sample < threshold);
        result.hit  = (sample <= threshold);
    end

endmodule

### src/ioft_merge.sv
// Merging stage: gathers the lane compares into the near mask and the received bit.
module ioft_merge
    import ioft_pkg::*;
(
    input  lane_res_t [SENSOR_COUNT-1:0] lane_res,
    output logic      [SENSOR_COUNT-1:0] near_mask,
    output logic                         rx_bit
);

    // The minimum reading is at or below the threshold exactly when any reading is.
    always_comb begin
        rx_bit = 1'b0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            near_mask[i] = lane_res[i].near;
            rx_bit       = rx_bit | lane_res[i].hit;
        end
    end

endmodule

### src/ioft_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ioft_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/ioft_checker.sv
// Port-level checker for the IR on-off frame transceiver and its bind.
`include "ir_onoff_frame_transceiver_macros.svh"

module ioft_checker
    import ioft_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    `IOFT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result item changed")
    `IOFT_ASSERT_SAME(a_word_zero, aclk, aresetn, m_valid && !m_data.rx_word_valid, m_data.rx_word == '0 && !m_data.rx_frame_end, "receive fields set without a word")
    `IOFT_ASSERT_SAME(a_full_enq, aclk, aresetn, m_valid && m_data.tx_full, m_data.near_mask == '0 && !m_data.rx_word_valid, "dropped enqueue carries frame results")
    `IOFT_ASSERT_SAME(a_end_word, aclk, aresetn, m_valid && m_data.rx_frame_end, m_data.rx_word_valid, "frame end without a word")
    `IOFT_ASSERT_SAME(a_ready_held, aclk, aresetn, !s_ready, m_valid, "input held off with no result item waiting")

endmodule

bind ir_onoff_frame_transceiver ioft_checker u_ioft_checker (.*);
